// ===== hw/rtl/wpm_pkg.sv =====
// Shared constants, types and helpers of the windowed peak level meter.
package wpm_pkg;

    // Sample and level formats
    localparam int SAMPLE_W   = 16;
    localparam int LVL_W      = 16;
    localparam int WINDOW_LEN = 512;
    localparam int CNT_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

    // Q1.15 constants; ONE_Q15 and TENTH_Q15 are 17 bits so that 1.0 is representable
    localparam logic [LVL_W:0]   ONE_Q15         = 17'd32768;
    localparam logic [LVL_W:0]   TENTH_Q15       = 17'd3277;
    localparam logic [LVL_W-1:0] NINE_TENTHS_Q15 = 16'd29491;
    localparam logic [31:0]      ROUND_Q15       = 32'd16384;

    // Full scale of a sample and the normalizing divide
    localparam logic [SAMPLE_W-1:0] FS_Q      = SAMPLE_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam int                  NORM_SH   = 30;
    localparam int                  DIV_STEPS = SAMPLE_W + NORM_SH;
    localparam int                  DIV_CNT_W = $clog2(DIV_STEPS);

    // Square root and multiplier sizes
    localparam int X_W        = 32;
    localparam int ROOT_W     = X_W / 2;
    localparam int ROOT_CNT_W = $clog2(ROOT_W);
    localparam int MUL_W      = 16;
    localparam int MUL_CNT_W  = $clog2(MUL_W);

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SMOOTHING = 2'd0,
        CFG_FLOOR     = 2'd1,
        CFG_GAIN      = 2'd2
    } cfg_idx_t;

    // Configuration values handed to the window engine
    typedef struct packed {
        logic [LVL_W-1:0] coeff;
        logic [LVL_W-1:0] floor_lvl;
        logic [LVL_W-1:0] gain;
    } wpm_cfg_t;

    // One finished window
    typedef struct packed {
        logic [SAMPLE_W-1:0] peak;
        logic [LVL_W-1:0]    level;
    } wpm_result_t;

    // Window engine sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQRT,
        ST_MUL_WL,
        ST_WL,
        ST_MUL_S1,
        ST_MUL_S2,
        ST_SMOOTH,
        ST_MUL_G,
        ST_LEVEL,
        ST_OUT
    } wpm_state_t;

    // Saturate a 17-bit Q1.15 value to 1.0
    function automatic logic [LVL_W-1:0] sat_one(input logic [LVL_W:0] v);
        logic [LVL_W-1:0] r;
        r = (v > ONE_Q15) ? ONE_Q15[LVL_W-1:0] : v[LVL_W-1:0];
        return r;
    endfunction

endpackage

// ===== hw/rtl/wpm_div.sv =====
// Bit-serial restoring divider: peak * 2^30 / full scale, one quotient bit per cycle.
module wpm_div import wpm_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start_i,
    input  logic [SAMPLE_W-1:0] peak_i,
    output logic                done_o,
    output logic [X_W-1:0]      quot_o
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [SAMPLE_W-1:0]  num_reg;
    logic [SAMPLE_W-2:0]  rem_reg;
    logic [X_W-1:0]       quot_reg;

    logic [SAMPLE_W-1:0]  trial;
    logic [SAMPLE_W-1:0]  diff;
    logic                 ge;

    // Next remainder bit comes from the dividend, zeros after the peak bits.
    assign trial = {rem_reg, num_reg[SAMPLE_W-1]};
    assign ge    = (trial >= FS_Q);
    assign diff  = trial - FS_Q;

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start_i) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath shift registers
    always_ff @(posedge aclk) begin
        if (start_i) begin
            cnt_reg  <= DIV_CNT_W'(DIV_STEPS - 1);
            num_reg  <= peak_i;
            rem_reg  <= '0;
            quot_reg <= '0;
        end else if (busy_reg) begin
            cnt_reg  <= cnt_reg - 1'b1;
            num_reg  <= {num_reg[SAMPLE_W-2:0], 1'b0};
            rem_reg  <= ge ? diff[SAMPLE_W-2:0] : trial[SAMPLE_W-2:0];
            quot_reg <= {quot_reg[X_W-2:0], ge};
        end
    end

    assign done_o = done_reg;
    assign quot_o = quot_reg;

endmodule

// ===== hw/rtl/wpm_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle.
module wpm_sqrt import wpm_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start_i,
    input  logic [X_W-1:0]    x_i,
    output logic              done_o,
    output logic [ROOT_W-1:0] root_o
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [ROOT_CNT_W-1:0] cnt_reg;
    logic [X_W-1:0]        x_reg;
    logic [ROOT_W:0]       rem_reg;
    logic [ROOT_W-1:0]     root_reg;

    logic [ROOT_W+2:0]     cur;
    logic [ROOT_W+2:0]     trial;
    logic [ROOT_W+2:0]     diff;
    logic                  ge;

    // Bring down two radicand bits and try the next root bit.
    assign cur   = {rem_reg, x_reg[X_W-1:X_W-2]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign ge    = (cur >= trial);
    assign diff  = cur - trial;

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start_i) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Remainder stays below twice the partial root, so it fits ROOT_W+1 bits.
    always_ff @(posedge aclk) begin
        if (start_i) begin
            cnt_reg  <= ROOT_CNT_W'(ROOT_W - 1);
            x_reg    <= x_i;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            cnt_reg  <= cnt_reg - 1'b1;
            x_reg    <= {x_reg[X_W-3:0], 2'b00};
            rem_reg  <= ge ? diff[ROOT_W:0] : cur[ROOT_W:0];
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

    assign done_o = done_reg;
    assign root_o = root_reg;

endmodule

// ===== hw/rtl/wpm_mul.sv =====
// Shift-and-add multiplier, one multiplier bit per cycle.
module wpm_mul import wpm_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start_i,
    input  logic [MUL_W-1:0]   a_i,
    input  logic [MUL_W-1:0]   b_i,
    output logic               done_o,
    output logic [2*MUL_W-1:0] prod_o
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic [MUL_W-1:0]     a_reg;
    logic [MUL_W-1:0]     hi_reg;
    logic [MUL_W-1:0]     lo_reg;

    logic [MUL_W:0]       sum;

    // Partial sum for the current low bit of the multiplier
    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start_i) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Product shifts right through hi and lo as multiplier bits are used up.
    always_ff @(posedge aclk) begin
        if (start_i) begin
            cnt_reg <= MUL_CNT_W'(MUL_W - 1);
            a_reg   <= a_i;
            hi_reg  <= '0;
            lo_reg  <= b_i;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            hi_reg  <= sum[MUL_W:1];
            lo_reg  <= {sum[0], lo_reg[MUL_W-1:1]};
        end
    end

    assign done_o = done_reg;
    assign prod_o = {hi_reg, lo_reg};

endmodule

// ===== hw/rtl/wpm_engine.sv =====
// Per-window sequencer: normalize, square root, level map, smoothing and output gain.
module wpm_engine import wpm_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start_i,
    input  logic [SAMPLE_W-1:0] peak_i,
    input  wpm_cfg_t            cfg_i,
    input  logic                slot_free_i,
    output logic                busy_o,
    output logic                out_valid_o,
    output wpm_result_t         result_o
);

    wpm_state_t          state_reg;
    wpm_state_t          state_next;
    logic                enter_reg;
    logic [SAMPLE_W-1:0] peak_reg;
    logic [LVL_W-1:0]    wl_reg;
    logic [LVL_W-1:0]    smooth_reg;
    logic [2*MUL_W-1:0]  p1_reg;
    wpm_result_t         result_reg;

    logic                div_start;
    logic                div_done;
    logic [X_W-1:0]      div_quot;
    logic                sqrt_start;
    logic                sqrt_done;
    logic [ROOT_W-1:0]   sqrt_root;
    logic                mul_start;
    logic                mul_done;
    logic [MUL_W-1:0]    mul_a;
    logic [MUL_W-1:0]    mul_b;
    logic [2*MUL_W-1:0]  mul_p;

    logic [LVL_W-1:0]    c_sat;
    logic [LVL_W-1:0]    fl_sat;
    logic [LVL_W-1:0]    g_sat;
    logic [LVL_W-1:0]    one_minus_c;
    logic [31:0]         prod_rnd;
    logic [LVL_W-1:0]    prod_q15;
    logic [LVL_W:0]      wl_sum;
    logic [LVL_W-1:0]    wl_clamped;
    logic [31:0]         smooth_sum;
    logic [LVL_W:0]      lvl_sum;

    // Serial arithmetic units
    wpm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (div_start),
        .peak_i  (peak_reg),
        .done_o  (div_done),
        .quot_o  (div_quot)
    );

    wpm_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (sqrt_start),
        .x_i     (div_quot),
        .done_o  (sqrt_done),
        .root_o  (sqrt_root)
    );

    wpm_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (mul_start),
        .a_i     (mul_a),
        .b_i     (mul_b),
        .done_o  (mul_done),
        .prod_o  (mul_p)
    );

    // Registers above 1.0 act as 1.0.
    assign c_sat       = sat_one({1'b0, cfg_i.coeff});
    assign fl_sat      = sat_one({1'b0, cfg_i.floor_lvl});
    assign g_sat       = sat_one({1'b0, cfg_i.gain});
    assign one_minus_c = LVL_W'(ONE_Q15 - {1'b0, c_sat});

    // Rounded Q15 product; every product here stays below 2^31.
    assign prod_rnd = mul_p + ROUND_Q15;
    assign prod_q15 = prod_rnd[30:15];

    // Window level: floor plus 0.9 * root, kept within [0.1, 1.0].
    assign wl_sum = {1'b0, fl_sat} + {1'b0, prod_q15};
    always_comb begin
        if (wl_sum > ONE_Q15) begin
            wl_clamped = ONE_Q15[LVL_W-1:0];
        end else if (wl_sum < TENTH_Q15) begin
            wl_clamped = TENTH_Q15[LVL_W-1:0];
        end else begin
            wl_clamped = wl_sum[LVL_W-1:0];
        end
    end

    // Moving average and output level sums
    assign smooth_sum = p1_reg + mul_p + ROUND_Q15;
    assign lvl_sum    = {1'b0, fl_sat} + {1'b0, prod_q15};

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (start_i)     state_next = ST_DIV;
            ST_DIV:    if (div_done)    state_next = ST_SQRT;
            ST_SQRT:   if (sqrt_done)   state_next = ST_MUL_WL;
            ST_MUL_WL: if (mul_done)    state_next = ST_WL;
            ST_WL:                      state_next = ST_MUL_S1;
            ST_MUL_S1: if (mul_done)    state_next = ST_MUL_S2;
            ST_MUL_S2: if (mul_done)    state_next = ST_SMOOTH;
            ST_SMOOTH:                  state_next = ST_MUL_G;
            ST_MUL_G:  if (mul_done)    state_next = ST_LEVEL;
            ST_LEVEL:                   state_next = ST_OUT;
            ST_OUT:    if (slot_free_i) state_next = ST_IDLE;
            default:                    state_next = ST_IDLE;
        endcase
    end

    // Outputs: unit starts on the first cycle of a state, multiplier operands.
    always_comb begin
        div_start   = 1'b0;
        sqrt_start  = 1'b0;
        mul_start   = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        out_valid_o = 1'b0;
        busy_o      = (state_reg != ST_IDLE);
        case (state_reg)
            ST_DIV: begin
                div_start = enter_reg;
            end
            ST_SQRT: begin
                sqrt_start = enter_reg;
            end
            ST_MUL_WL: begin
                mul_start = enter_reg;
                mul_a     = sqrt_root;
                mul_b     = NINE_TENTHS_Q15;
            end
            ST_MUL_S1: begin
                mul_start = enter_reg;
                mul_a     = smooth_reg;
                mul_b     = one_minus_c;
            end
            ST_MUL_S2: begin
                mul_start = enter_reg;
                mul_a     = wl_reg;
                mul_b     = c_sat;
            end
            ST_MUL_G: begin
                mul_start = enter_reg;
                mul_a     = g_sat;
                mul_b     = smooth_reg;
            end
            ST_OUT: begin
                out_valid_o = slot_free_i;
            end
            default: begin
                out_valid_o = 1'b0;
            end
        endcase
    end

    // State and smoothing history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            enter_reg  <= 1'b0;
            smooth_reg <= '0;
        end else begin
            state_reg <= state_next;
            enter_reg <= (state_next != state_reg);
            if (state_reg == ST_SMOOTH) begin
                smooth_reg <= sat_one(smooth_sum[31:15]);
            end
        end
    end

    // Intermediate values of the window being finished
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && start_i) begin
            peak_reg <= peak_i;
        end
        if (state_reg == ST_WL) begin
            wl_reg <= wl_clamped;
        end
        if (state_reg == ST_MUL_S1 && mul_done) begin
            p1_reg <= mul_p;
        end
        if (state_reg == ST_LEVEL) begin
            result_reg.level <= sat_one(lvl_sum);
            result_reg.peak  <= peak_reg;
        end
    end

    assign result_o = result_reg;

    // A new window is only handed over while the sequencer is free.
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start_i |-> state_reg == ST_IDLE)
        else $error("window start while engine busy");

    // The shared multiplier finishes only in a state that waits for it.
    a_mul_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == ST_MUL_WL || state_reg == ST_MUL_S1 ||
                      state_reg == ST_MUL_S2 || state_reg == ST_MUL_G))
        else $error("multiplier result in unexpected state");

    // The window level is clamped before it enters the average.
    a_wl_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MUL_S2 |->
            ({1'b0, wl_reg} >= TENTH_Q15 && {1'b0, wl_reg} <= ONE_Q15))
        else $error("window level out of range");

    // Output level lies within [floor, 1.0].
    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_o |->
            ({1'b0, result_reg.level} <= ONE_Q15 && result_reg.level >= fl_sat))
        else $error("output level out of range");

    // Handing a result to the output register frees the engine.
    a_out_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_o |=> state_reg == ST_IDLE)
        else $error("engine stayed busy after result handoff");

endmodule

// ===== hw/rtl/windowed_peak_level_meter.sv =====
// Top level: sample front end, configuration registers, window engine and output register.
// Throughput: one sample per cycle; a window-closing request is held off while the engine
//   works on the previous window or that window's result waits for the output register.
// Path: a request that closes a window runs through the 46-step divider, the root, four
//   multiplies and the single-step states, then loads the output register for m_tvalid.
// Reset: synchronous, active low; clears peak, count and average, and loads default registers.
module windowed_peak_level_meter import wpm_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [LVL_W-1:0]     cfg_wdata,
    // Sample stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [15:0] sample
    input  logic                 s_tlast,   // end_of_stream
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata    // [15:0] level, [31:16] window_peak
);

    wpm_cfg_t            cfg_reg;
    logic [SAMPLE_W-1:0] peak_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                m_tvalid_reg;
    wpm_result_t         m_data_reg;

    logic                s_acc;
    logic [SAMPLE_W-1:0] mag;
    logic [SAMPLE_W-1:0] peak_next;
    logic                win_last;
    logic                eng_start;
    logic                eng_busy;
    logic                eng_out_valid;
    logic                slot_free;
    wpm_result_t         eng_result;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.coeff     <= 16'd3277;
            cfg_reg.floor_lvl <= 16'd3277;
            cfg_reg.gain      <= 16'd16384;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_SMOOTHING: cfg_reg.coeff     <= cfg_wdata;
                CFG_FLOOR:     cfg_reg.floor_lvl <= cfg_wdata;
                CFG_GAIN:      cfg_reg.gain      <= cfg_wdata;
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    // Magnitude of the sample; the most negative code maps to full scale plus one.
    assign mag       = s_tdata[SAMPLE_W-1] ? (~s_tdata + 1'b1) : s_tdata;
    assign peak_next = (mag > peak_reg) ? mag : peak_reg;
    assign win_last  = s_tlast || (count_reg == CNT_W'(WINDOW_LEN - 1));

    // A window-closing request waits until the engine can take it.
    assign s_tready  = !eng_busy || !win_last;
    assign s_acc     = s_tvalid && s_tready;
    assign eng_start = s_acc && win_last;

    // Peak and count of the open window
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_reg  <= '0;
            count_reg <= '0;
        end else if (s_acc) begin
            if (win_last) begin
                peak_reg  <= '0;
                count_reg <= '0;
            end else begin
                peak_reg  <= peak_next;
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    wpm_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start_i     (eng_start),
        .peak_i      (peak_next),
        .cfg_i       (cfg_reg),
        .slot_free_i (slot_free),
        .busy_o      (eng_busy),
        .out_valid_o (eng_out_valid),
        .result_o    (eng_result)
    );

    // Output register
    assign slot_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (eng_out_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (eng_out_valid) begin
            m_data_reg <= eng_result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_data_reg.peak, m_data_reg.level};

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench of the windowed peak level meter, run against a window-level predictor.
`timescale 1ns / 100ps

module tb_top;
    import wpm_pkg::*;

    // Run control
    localparam int DRAIN_CYCLES   = 200;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 3000;
    localparam int RANDOM_ITEMS   = 1700;
    localparam int RANDOM_WINDOWS = 60;
    localparam int PHASE_ITEMS    = 150;

    // Q1.15 arithmetic constants of the level path
    localparam logic [63:0] Q15_ONE         = 64'd32768;
    localparam logic [63:0] Q15_TENTH       = 64'd3277;
    localparam logic [63:0] Q15_NINE_TENTHS = 64'd29491;
    localparam logic [63:0] Q15_HALF        = 64'd16384;
    localparam logic [63:0] SAMPLE_FS       = 64'd32767;

    // Register index that maps to no register
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // One finished window, laid out as on m_tdata
    typedef struct packed {
        logic [15:0] peak;
        logic [15:0] level;
    } meter_result_t;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_WRITE
    } row_kind_t;

    // One row of the directed table: a sample request or a register write
    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  addr;
        logic [15:0]           value;
        logic                  last;
        logic                  typed;
        meter_result_t         want;
    } stim_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [LVL_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata = '0;    // [15:0] sample
    logic                 s_tlast = 1'b0;  // end_of_stream
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [31:0]          m_tdata;         // [15:0] level, [31:16] window_peak

    // Predictor copy of the registers and of the open window
    logic [15:0] reg_coeff = 16'd3277;
    logic [15:0] reg_floor = 16'd3277;
    logic [15:0] reg_gain  = 16'd16384;
    logic [15:0] open_peak = 16'd0;
    logic [15:0] ema_level = 16'd0;
    int          open_count = 0;

    meter_result_t level_q[$];
    meter_result_t mon_got;
    meter_result_t mon_want;

    int samples_sent   = 0;
    int windows_closed = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int burst_left     = 0;
    bit hold_off_req   = 1'b0;

    // Directed rows; levels are typed in only where they follow directly from the settings
    stim_row_t dir_rows [24] = '{
        '{ROW_SAMPLE, CFG_SMOOTHING, 16'h0000, 1'b1, 1'b1, '{16'd0, 16'd3441}},
        '{ROW_SAMPLE, CFG_SMOOTHING, 16'h7FFF, 1'b0, 1'b0, 32'd0},
        '{ROW_SAMPLE, CFG_SMOOTHING, 16'h8000, 1'b1, 1'b0, 32'd0},
        '{ROW_SAMPLE, CFG_SMOOTHING, 16'hFFFF, 1'b0, 1'b0, 32'd0},
        '{ROW_SAMPLE, CFG_SMOOTHING, 16'h0001, 1'b1, 1'b0, 32'd0},
        '{ROW_WRITE,  CFG_SMOOTHING, 16'hFFFF, 1'b0, 1'b0, 32'd0},
        '{ROW_WRITE,  CFG_FLOOR,     16'h0000, 1'b0, 1'b0, 32'd0},
        '{ROW_WRITE,  CFG_GAIN,      16'h8000, 1'b0, 1'b0, 32'd0},
        '{ROW_SAMPLE, CFG_SMOOTHING, 16'h8000, 1'b1, 1'b1, '{16'd32768, 16'd29491}},
        '{ROW_SAMPLE, CFG_SMOOTHING, 16'h0000, 1'b1, 1'b1, '{16'd0, 16'd3277}},
        '{ROW_SAMPLE, CFG_SMOOTHING, 16'h7FFF, 1'b1, 1'b1, '{16'd32767, 16'd29491}},
        '{ROW_WRITE,  CFG_SPARE,     16'h0000, 1'b0, 1'b0, 32'd0},
        '{ROW_SAMPLE, CFG_SMOOTHING, 16'h8001, 1'b1, 1'b1, '{16'd32767, 16'd29491}},
        '{ROW_WRITE,  CFG_FLOOR,     16'h8000, 1'b0, 1'b0, 32'd0},
        '{ROW_SAMPLE, CFG_SMOOTHING, 16'h0064, 1'b1, 1'b1, '{16'd100, 16'd32768}},
        '{ROW_WRITE,  CFG_FLOOR,     16'hFFFF, 1'b0, 1'b0, 32'd0},
        '{ROW_SAMPLE, CFG_SMOOTHING, 16'hFFFB, 1'b1, 1'b1, '{16'd5, 16'd32768}},
        '{ROW_WRITE,  CFG_SMOOTHING, 16'h0000, 1'b0, 1'b0, 32'd0},
        '{ROW_WRITE,  CFG_FLOOR,     16'h0CCD, 1'b0, 1'b0, 32'd0},
        '{ROW_WRITE,  CFG_GAIN,      16'h0000, 1'b0, 1'b0, 32'd0},
        '{ROW_SAMPLE, CFG_SMOOTHING, 16'h8001, 1'b1, 1'b1, '{16'd32767, 16'd3277}},
        '{ROW_WRITE,  CFG_GAIN,      16'hFFFF, 1'b0, 1'b0, 32'd0},
        '{ROW_SAMPLE, CFG_SMOOTHING, 16'h1234, 1'b0, 1'b0, 32'd0},
        '{ROW_SAMPLE, CFG_SMOOTHING, 16'hEDCC, 1'b1, 1'b0, 32'd0}
    };

    windowed_peak_level_meter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Values above 1.0 count as 1.0
    function automatic logic [63:0] clip_one(input logic [63:0] v);
        return (v > Q15_ONE) ? Q15_ONE : v;
    endfunction

    // Integer square root, one result bit per pass
    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        rem  = v;
        res  = 64'd0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 64'd0) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Fold one sample into the open window; on a window end work out its display level
    task automatic predict_window_level(input logic [15:0] smp, input logic last,
                                        output bit closed, output meter_result_t res);
        int          sval;
        logic [63:0] mag;
        logic [63:0] c;
        logic [63:0] fl;
        logic [63:0] g;
        logic [63:0] x;
        logic [63:0] rt;
        logic [63:0] wl;
        logic [63:0] acc;
        sval = $signed(smp);
        mag  = (sval < 0) ? 64'(-sval) : 64'(sval);
        if (mag > 64'(open_peak)) open_peak = mag[15:0];
        open_count++;
        closed = (open_count >= WINDOW_LEN) || last;
        res    = '0;
        if (closed) begin
            c  = clip_one(64'(reg_coeff));
            fl = clip_one(64'(reg_floor));
            g  = clip_one(64'(reg_gain));
            // Normalized peak, square root, then the window level
            x  = (64'(open_peak) << 30) / SAMPLE_FS;
            rt = clip_one(int_sqrt(x));
            wl = clip_one(fl + ((Q15_NINE_TENTHS * rt + Q15_HALF) >> 15));
            if (wl < Q15_TENTH) wl = Q15_TENTH;
            // Moving average, then gain and floor
            acc = 64'(ema_level) * (Q15_ONE - c) + wl * c + Q15_HALF;
            acc = clip_one(acc >> 15);
            ema_level = acc[15:0];
            acc = clip_one(fl + ((g * 64'(ema_level) + Q15_HALF) >> 15));
            if (acc < fl) acc = fl;
            res.level  = acc[15:0];
            res.peak   = open_peak;
            open_peak  = 16'd0;
            open_count = 0;
        end
    endtask

    // Offer one sample request in the current burst and record what it should produce
    task automatic push_sample(input logic [15:0] smp, input logic last, input logic typed,
                               input meter_result_t typed_want);
        int            gap;
        bit            closed;
        meter_result_t predicted;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        samples_sent++;
        predict_window_level(smp, last, closed, predicted);
        if (closed) begin
            level_q.push_back(typed ? typed_want : predicted);
            windows_closed++;
        end
    endtask

    // Write one register; the caller drops the write enable after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_SMOOTHING: reg_coeff = val;
            CFG_FLOOR:     reg_floor = val;
            CFG_GAIN:      reg_gain  = val;
            default: ;
        endcase
    endtask

    // Stop sending, wait for every pending window result, then let the engine settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (level_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Register values with the extremes and values above 1.0 well represented
    function automatic logic [15:0] pick_reg_value();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'h8000;
            2:       return 16'hFFFF;
            3:       return 16'($urandom);
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    // A sample at the window's loudness, now and then a full-scale or edge value
    function automatic logic [15:0] draw_sample(input int sh);
        logic signed [15:0] v;
        if ($urandom_range(0, 15) == 0) begin
            case ($urandom_range(0, 5))
                0:       return 16'h8000;
                1:       return 16'h7FFF;
                2:       return 16'h8001;
                3:       return 16'hFFFF;
                4:       return 16'h0001;
                default: return 16'h0000;
            endcase
        end
        v = $signed(16'($urandom));
        return 16'(v >>> sh);
    endfunction

    function automatic void flag_mismatch(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
    endfunction

    // Result side: compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            mon_got = m_tdata;
            if (level_q.size() == 0) begin
                flag_mismatch("unrequested result", 32'd0, mon_got);
            end else begin
                mon_want = level_q.pop_front();
                if (mon_got.level !== mon_want.level)
                    flag_mismatch("level", 32'(mon_want.level), 32'(mon_got.level));
                if (mon_got.peak !== mon_want.peak)
                    flag_mismatch("window_peak", 32'(mon_want.peak), 32'(mon_got.peak));
            end
        end
    end

    // Watchdog on cycles in which neither side moves a request
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Receiver: runs of stalls, toggling and steady ready, plus one long hold-off on request
    initial begin : receiver
        int run;
        int mode;
        forever begin
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end else begin
                mode = $urandom_range(0, 9);
                run  = (mode == 9) ? 200 : $urandom_range(1, 24);
                for (int i = 0; i < run; i++) begin
                    case (mode)
                        0, 1, 2: m_tready <= 1'b0;
                        3, 4:    m_tready <= i[0];
                        default: m_tready <= 1'b1;
                    endcase
                    @(posedge aclk);
                end
            end
        end
    end

    // Sender: reset, directed table, then phases of random windows under random settings
    initial begin : stimulus
        int          phase;
        int          phase_items;
        int          wlen;
        int          sh;
        int          first_sample;
        int          first_window;
        logic        last;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_WRITE) begin
                wait_drained();
                write_reg(dir_rows[r].addr, dir_rows[r].value);
                cfg_wr_en <= 1'b0;
            end else begin
                push_sample(dir_rows[r].value, dir_rows[r].last, dir_rows[r].typed,
                            dir_rows[r].want);
            end
        end

        first_sample = samples_sent;
        first_window = windows_closed;
        phase = 0;
        while (!((samples_sent - first_sample >= RANDOM_ITEMS) &&
                 (windows_closed - first_window >= RANDOM_WINDOWS))) begin
            // New settings only once the block is idle
            wait_drained();
            write_reg(CFG_SMOOTHING, pick_reg_value());
            write_reg(CFG_FLOOR, pick_reg_value());
            write_reg(CFG_GAIN, pick_reg_value());
            if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, 16'($urandom));
            cfg_wr_en <= 1'b0;

            // Full windows: closed by the count and the end flag together, then by the count alone
            if (phase == 0) begin
                sh = $urandom_range(0, 15);
                for (int i = 0; i < WINDOW_LEN; i++)
                    push_sample(draw_sample(sh), i == WINDOW_LEN - 1, 1'b0, 32'd0);
                sh = $urandom_range(0, 15);
                for (int i = 0; i < WINDOW_LEN; i++)
                    push_sample(draw_sample(sh), 1'b0, 1'b0, 32'd0);
            end

            // Receiver holds off while one-sample windows pile up behind the output
            if (phase == 2) begin
                hold_off_req = 1'b1;
                repeat (12) push_sample(draw_sample($urandom_range(0, 15)), 1'b1, 1'b0, 32'd0);
            end

            // Mostly short windows closed by the end flag, now and then a full one
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                wlen = ($urandom_range(0, 99) == 0) ? WINDOW_LEN : $urandom_range(1, 24);
                sh   = $urandom_range(0, 15);
                for (int i = 0; i < wlen; i++) begin
                    last = (i == wlen - 1) && ((wlen < WINDOW_LEN) || ($urandom_range(0, 1) == 1));
                    push_sample(draw_sample(sh), last, 1'b0, 32'd0);
                end
                phase_items += wlen;
            end
            phase++;
        end

        wait_drained();
        if (mismatch_count == 0 && level_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/wpm_pkg.sv
hw/rtl/wpm_div.sv
hw/rtl/wpm_sqrt.sv
hw/rtl/wpm_mul.sv
hw/rtl/wpm_engine.sv
hw/rtl/windowed_peak_level_meter.sv
test/tb_top.sv
